[design/lfu_pkg.sv]
// ----------------------------------------------------------------------------
// LFU slot cache package
// Shared widths, beat payload types and the record that travels along the
// chain of slot cells.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

  localparam int KEY_W     = 21;
  localparam int HANDLE_W  = 32;
  localparam int SLOT_W    = 6;
  localparam int SLOTS_DEF = 10;
  localparam int HIT_DEF   = 16;

  typedef struct packed {
    logic                req_type;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } lfu_req_t;

  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] data_out;
    logic [SLOT_W-1:0]   slot;
    logic                evicted;
    logic [HANDLE_W-1:0] evicted_handle;
  } lfu_rsp_t;

  // Request record handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic                valid;
    logic                req_type;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic                done;
    logic                hit;
    logic [HANDLE_W-1:0] data;
    logic [SLOT_W-1:0]   slot;
    logic                have_min;
    logic [HANDLE_W-1:0] evh;
  } lfu_tok_t;

  // Replacement write broadcast to all cells after a full scan.
  typedef struct packed {
    logic                en;
    logic [SLOT_W-1:0]   slot;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } lfu_wr_t;

endpackage

`default_nettype wire

[design/lfu_cell.sv]
// ----------------------------------------------------------------------------
// LFU slot cell
// Holds one slot (key, hit count, handle), serves the passing request record
// and takes part in the least-frequently-used search.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cell
  import lfu_pkg::*;
#(
  parameter int IDX      = 0,
  parameter int HIT_BITS = HIT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lfu_tok_t            tok_in,
  input  wire logic [HIT_BITS-1:0] min_in,
  input  wire lfu_wr_t             wr,
  output lfu_tok_t                 tok_out,
  output logic [HIT_BITS-1:0]      min_out
);

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

  logic [KEY_W-1:0]    slot_key;
  logic [HIT_BITS-1:0] hit_count;
  logic [HANDLE_W-1:0] slot_handle;

  lfu_tok_t            tok_next;
  logic [HIT_BITS-1:0] min_next;
  logic [KEY_W-1:0]    slot_key_next;
  logic [HIT_BITS-1:0] hit_count_next;
  logic                fill;

  always_comb begin
    tok_next       = tok_in;
    min_next       = min_in;
    slot_key_next  = slot_key;
    hit_count_next = hit_count;
    fill           = 1'b0;
    if (tok_in.valid && !tok_in.done) begin
      if (!tok_in.req_type) begin
        if (slot_key == tok_in.key) begin
          tok_next.done = 1'b1;
          tok_next.hit  = 1'b1;
          tok_next.data = slot_handle;
          tok_next.slot = MY_SLOT;
          if (hit_count != '1) begin
            hit_count_next = hit_count + 1'b1;
          end
        end
      end else if (slot_key == '0) begin
        tok_next.done  = 1'b1;
        tok_next.slot  = MY_SLOT;
        slot_key_next  = tok_in.key;
        hit_count_next = '0;
        fill           = 1'b1;
      end else if (!tok_in.have_min || (hit_count < min_in)) begin
        tok_next.have_min = 1'b1;
        tok_next.slot     = MY_SLOT;
        tok_next.evh      = slot_handle;
        min_next          = hit_count;
      end
    end
    if (wr.en && (wr.slot == MY_SLOT)) begin
      slot_key_next  = wr.key;
      hit_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_key  <= '0;
      hit_count <= '0;
      tok_out   <= '0;
    end else begin
      slot_key  <= slot_key_next;
      hit_count <= hit_count_next;
      tok_out   <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    min_out <= min_next;
    if (fill) begin
      slot_handle <= tok_in.handle;
    end else if (wr.en && (wr.slot == MY_SLOT)) begin
      slot_handle <= wr.handle;
    end
  end

endmodule

`default_nettype wire

[design/lfu_cache_slot_manager.sv]
// ----------------------------------------------------------------------------
// LFU cache slot manager
// Fully associative key-to-handle cache with least-frequently-used
// replacement, built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage: a request beat on req (req_valid/req_stall) is a lookup or an insert.
// Every request gives exactly one response beat on rsp (rsp_valid/rsp_stall).
// The request record walks the chain of SLOTS cells, one cell per cycle, and
// its response is then registered into the output or skid register. One
// request is in flight at a time: a new request is taken only after the record
// has left the cell chain. An eviction writes the chosen slot in the cycle the
// record leaves the chain.
// A finished response sits in the output register while the next request
// is taken; a second finished response waits in a skid register, and no
// new request is taken until that register drains.
// Reset empties every slot and clears all hit counts and both output stages.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cache_slot_manager
  import lfu_pkg::*;
#(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int HIT_BITS = HIT_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_stall,
  input  wire lfu_req_t req,
  output logic          rsp_valid,
  input  wire logic     rsp_stall,
  output lfu_rsp_t      rsp
);

  lfu_tok_t            tok  [SLOTS];
  logic [HIT_BITS-1:0] minc [SLOTS];
  lfu_tok_t            tok_first;
  lfu_tok_t            tok_last;
  lfu_wr_t             wr;
  lfu_rsp_t            result;
  lfu_rsp_t            skid;
  logic                skid_valid;
  logic                busy;
  logic                take;

  assign req_stall = busy | skid_valid;
  assign take      = req_valid & ~req_stall;

  always_comb begin
    tok_first          = '0;
    tok_first.valid    = take;
    tok_first.req_type = req.req_type;
    tok_first.key      = req.key;
    tok_first.handle   = req.handle;
    tok_first.done     = (req.key == '0);
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_head
      lfu_cell #(.IDX(i), .HIT_BITS(HIT_BITS)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .tok_in  (tok_first),
        .min_in  ({HIT_BITS{1'b0}}),
        .wr      (wr),
        .tok_out (tok[i]),
        .min_out (minc[i])
      );
    end else begin : g_body
      lfu_cell #(.IDX(i), .HIT_BITS(HIT_BITS)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .tok_in  (tok[i-1]),
        .min_in  (minc[i-1]),
        .wr      (wr),
        .tok_out (tok[i]),
        .min_out (minc[i])
      );
    end
  end

  assign tok_last = tok[SLOTS-1];

  always_comb begin
    wr.en                 = tok_last.valid & tok_last.req_type & ~tok_last.done;
    wr.slot               = tok_last.slot;
    wr.key                = tok_last.key;
    wr.handle             = tok_last.handle;
    result.hit            = tok_last.hit;
    result.data_out       = tok_last.hit ? tok_last.data : '0;
    result.slot           = tok_last.slot;
    result.evicted        = tok_last.req_type & ~tok_last.done;
    result.evicted_handle = result.evicted ? tok_last.evh : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (take) begin
        busy <= 1'b1;
      end else if (tok_last.valid) begin
        busy <= 1'b0;
      end
      if (!rsp_valid || !rsp_stall) begin
        if (skid_valid) begin
          rsp_valid  <= 1'b1;
          skid_valid <= tok_last.valid;
        end else begin
          rsp_valid <= tok_last.valid;
        end
      end else if (tok_last.valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rsp_valid || !rsp_stall) begin
      if (skid_valid) begin
        rsp <= skid;
        if (tok_last.valid) begin
          skid <= result;
        end
      end else if (tok_last.valid) begin
        rsp <= result;
      end
    end else if (tok_last.valid) begin
      skid <= result;
    end
  end

endmodule

`default_nettype wire

[dv/lfu_cache_slot_manager_test.sv]
// ----------------------------------------------------------------------------
// LFU cache slot manager testbench
// Drives lookup and insert beats into the slot cache, mirrors the cache in a
// local copy of its keys, hit counts and handles, and compares every response
// beat field by field. A directed table covers empty and full caches, key
// zero, duplicate keys, eviction ties and hit count saturation. Random
// traffic over a small pool of keys follows, under changing back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cache_slot_manager_test
  import lfu_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NSLOT       = SLOTS_DEF;
  // Narrow hit counts let the directed table and random traffic reach saturation.
  localparam int          HIT_W       = 4;
  localparam logic        REQ_LOOKUP  = 1'b0;
  localparam logic        REQ_INSERT  = 1'b1;
  localparam logic [KEY_W-1:0] KEY_TOP = '1;
  localparam lfu_rsp_t    NO_RESULT   = '0;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int          RANDOM_BEATS = 1600;
  localparam int          POOL_SIZE   = 16;

  typedef struct {
    lfu_req_t    beat;
    int unsigned reps;
    bit          typed;
    lfu_rsp_t    want;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  lfu_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  lfu_rsp_t rsp;

  logic [KEY_W-1:0]    cached_key    [NSLOT];
  logic [HIT_W-1:0]    use_count     [NSLOT];
  logic [HANDLE_W-1:0] cached_handle [NSLOT];
  logic [KEY_W-1:0]    key_pool      [POOL_SIZE];

  lfu_rsp_t    answers_due[$];
  int          errors;
  int          req_idle_pct;
  int          rsp_stall_pct;
  int unsigned cycle_count;
  int          n_lookups, n_inserts, n_hits, n_evictions, n_zero_keys;

  lfu_cache_slot_manager #(.SLOTS(NSLOT), .HIT_BITS(HIT_W)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Runs one request against the local copy of the cache and returns its answer.
  function automatic lfu_rsp_t apply_request(input lfu_req_t r);
    lfu_rsp_t         o;
    int               i;
    int               target;
    logic [HIT_W-1:0] least;
    bit               found_empty;
    o = NO_RESULT;
    if (r.key == '0) begin
      return o;
    end
    if (r.req_type == REQ_LOOKUP) begin
      for (i = 0; i < NSLOT; i++) begin
        if (cached_key[i] == r.key) begin
          if (use_count[i] != '1) use_count[i] = use_count[i] + 1'b1;
          o.hit      = 1'b1;
          o.data_out = cached_handle[i];
          o.slot     = SLOT_W'(i);
          return o;
        end
      end
      return o;
    end
    target      = 0;
    least       = use_count[0];
    found_empty = 1'b0;
    for (i = 0; i < NSLOT; i++) begin
      if (cached_key[i] == '0) begin
        target      = i;
        found_empty = 1'b1;
        break;
      end
      if (use_count[i] < least) begin
        least  = use_count[i];
        target = i;
      end
    end
    if (!found_empty) begin
      o.evicted        = 1'b1;
      o.evicted_handle = cached_handle[target];
    end
    use_count[target]     = '0;
    cached_key[target]    = r.key;
    cached_handle[target] = r.handle;
    o.slot                = SLOT_W'(target);
    return o;
  endfunction

  function automatic lfu_rsp_t result_of(input logic hit, input logic [HANDLE_W-1:0] data,
                                         input logic [SLOT_W-1:0] slot, input logic ev,
                                         input logic [HANDLE_W-1:0] evh);
    lfu_rsp_t o;
    o.hit            = hit;
    o.data_out       = data;
    o.slot           = slot;
    o.evicted        = ev;
    o.evicted_handle = evh;
    return o;
  endfunction

  function automatic stim_row_t mk_row(input logic kind, input logic [KEY_W-1:0] k,
                                       input logic [HANDLE_W-1:0] h, input int unsigned n,
                                       input bit typed, input lfu_rsp_t want);
    stim_row_t row;
    row.beat.req_type = kind;
    row.beat.key      = k;
    row.beat.handle   = h;
    row.reps          = n;
    row.typed         = typed;
    row.want          = want;
    return row;
  endfunction

  task automatic issue(input lfu_req_t r, input bit typed, input lfu_rsp_t want);
    lfu_rsp_t model;
    while ($urandom_range(0, 99) < req_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    model = apply_request(r);
    answers_due.push_back(typed ? want : model);
    if (r.key == '0) n_zero_keys++;
    if (r.req_type == REQ_LOOKUP) n_lookups++;
    else n_inserts++;
    if (model.hit) n_hits++;
    if (model.evicted) n_evictions++;
  endtask

  task automatic field_mismatch(input string name, input logic [63:0] want,
                                input logic [63:0] got);
    $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
    errors++;
  endtask

  initial begin
    lfu_rsp_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        if (answers_due.size() == 0) begin
          $display("%0t: response beat with nothing pending: expected none, actual %p",
                   $time, rsp);
          errors++;
        end else begin
          want = answers_due.pop_front();
          if (rsp.hit !== want.hit) field_mismatch("hit", 64'(want.hit), 64'(rsp.hit));
          if (rsp.data_out !== want.data_out)
            field_mismatch("data_out", 64'(want.data_out), 64'(rsp.data_out));
          if (rsp.slot !== want.slot)
            field_mismatch("slot", 64'(want.slot), 64'(rsp.slot));
          if (rsp.evicted !== want.evicted)
            field_mismatch("evicted", 64'(want.evicted), 64'(rsp.evicted));
          if (rsp.evicted_handle !== want.evicted_handle)
            field_mismatch("evicted_handle", 64'(want.evicted_handle),
                           64'(rsp.evicted_handle));
        end
      end
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("lfu_cache_slot_manager_test: FAIL");
    $finish;
  end

  initial begin
    stim_row_t       plan[$];
    lfu_req_t        beat;
    int              req_pcts[3];
    int              rsp_pcts[3];
    int              p, k, b, pick, hsel;
    int unsigned     r;
    errors        = 0;
    n_lookups     = 0;
    n_inserts     = 0;
    n_hits        = 0;
    n_evictions   = 0;
    n_zero_keys   = 0;
    req_pcts      = '{19, 76, 0};
    rsp_pcts      = '{76, 19, 0};
    req_idle_pct  = req_pcts[0];
    rsp_stall_pct = rsp_pcts[0];
    for (k = 0; k < NSLOT; k++) begin
      cached_key[k]    = '0;
      use_count[k]     = '0;
      cached_handle[k] = '0;
    end

    plan.push_back(mk_row(REQ_LOOKUP, 21'd1, 32'h0, 1, 1, NO_RESULT));
    plan.push_back(mk_row(REQ_LOOKUP, 21'd0, 32'h0, 1, 1, NO_RESULT));
    plan.push_back(mk_row(REQ_INSERT, 21'd0, 32'hFFFF_FFFF, 1, 1, NO_RESULT));
    plan.push_back(mk_row(REQ_INSERT, KEY_TOP, 32'hFFFF_FFFF, 1, 1,
                          result_of(1'b0, 32'h0, 6'd0, 1'b0, 32'h0)));
    plan.push_back(mk_row(REQ_INSERT, 21'd1, 32'h0, 1, 1,
                          result_of(1'b0, 32'h0, 6'd1, 1'b0, 32'h0)));
    plan.push_back(mk_row(REQ_LOOKUP, KEY_TOP, 32'h0, 1, 1,
                          result_of(1'b1, 32'hFFFF_FFFF, 6'd0, 1'b0, 32'h0)));
    plan.push_back(mk_row(REQ_LOOKUP, 21'd1, 32'h0, 1, 1,
                          result_of(1'b1, 32'h0, 6'd1, 1'b0, 32'h0)));
    plan.push_back(mk_row(REQ_INSERT, 21'd1, 32'h1234_5678, 1, 1,
                          result_of(1'b0, 32'h0, 6'd2, 1'b0, 32'h0)));
    plan.push_back(mk_row(REQ_LOOKUP, 21'd1, 32'h0, 1, 1,
                          result_of(1'b1, 32'h0, 6'd1, 1'b0, 32'h0)));
    for (k = 3; k < NSLOT; k++)
      plan.push_back(mk_row(REQ_INSERT, KEY_W'(k), 32'h5A00_0000 | k, 1, 0, NO_RESULT));
    plan.push_back(mk_row(REQ_INSERT, 21'd100, 32'hA5A5_A5A5, 1, 1,
                          result_of(1'b0, 32'h0, 6'd2, 1'b1, 32'h1234_5678)));
    plan.push_back(mk_row(REQ_LOOKUP, 21'd0, 32'hFFFF_FFFF, 1, 1, NO_RESULT));
    plan.push_back(mk_row(REQ_INSERT, 21'd0, 32'h0F0F_0F0F, 1, 1, NO_RESULT));
    plan.push_back(mk_row(REQ_LOOKUP, 21'h10FFFF, 32'h0, 1, 1, NO_RESULT));
    plan.push_back(mk_row(REQ_LOOKUP, 21'd100, 32'h0, 1, 0, NO_RESULT));
    // Drives the slot 0 count one past its maximum, where a wrap would make it the victim.
    plan.push_back(mk_row(REQ_LOOKUP, KEY_TOP, 32'h0, (1 << HIT_W) - 1, 0, NO_RESULT));
    plan.push_back(mk_row(REQ_INSERT, 21'h0ABCDE, 32'h0, 1, 1,
                          result_of(1'b0, 32'h0, 6'd3, 1'b1, 32'h5A00_0003)));
    plan.push_back(mk_row(REQ_LOOKUP, KEY_TOP, 32'h0, 1, 1,
                          result_of(1'b1, 32'hFFFF_FFFF, 6'd0, 1'b0, 32'h0)));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      repeat (plan[i].reps) issue(plan[i].beat, plan[i].typed, plan[i].want);
    end

    for (p = 0; p < 3; p++) begin
      req_idle_pct  = req_pcts[p];
      rsp_stall_pct = rsp_pcts[p];
      for (k = 0; k < POOL_SIZE; k++) key_pool[k] = KEY_W'($urandom_range(1, 21'h1FFFFF));
      for (b = 0; b < RANDOM_BEATS / 3 + 1; b++) begin
        pick = $urandom_range(0, 99);
        hsel = $urandom_range(0, 19);
        r    = $urandom();
        beat.handle = (hsel == 0) ? 32'h0 : (hsel == 1) ? 32'hFFFF_FFFF : r;
        if (pick < 55) begin
          beat.req_type = REQ_LOOKUP;
          beat.key      = key_pool[$urandom_range(0, $urandom_range(0, POOL_SIZE - 1))];
        end else if (pick < 85) begin
          beat.req_type = REQ_INSERT;
          beat.key      = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (pick < 90) begin
          beat.req_type = ($urandom_range(0, 1) == 0) ? REQ_LOOKUP : REQ_INSERT;
          beat.key      = '0;
        end else begin
          beat.req_type = ($urandom_range(0, 1) == 0) ? REQ_LOOKUP : REQ_INSERT;
          beat.key      = KEY_W'($urandom_range(1, 21'h1FFFFF));
        end
        issue(beat, 1'b0, NO_RESULT);
      end
    end
    req_valid <= 1'b0;

    while (answers_due.size() != 0) @(posedge clk);
    repeat (3 * (NSLOT + 1)) @(posedge clk);

    $display("Sent %0d lookups (%0d hits) and %0d inserts (%0d evictions), %0d with key zero,",
             n_lookups, n_hits, n_inserts, n_evictions, n_zero_keys);
    $display("under sender gaps and receiver back-pressure in both orders and with none.");
    if (errors == 0) begin
      $display("lfu_cache_slot_manager_test: PASS");
    end else begin
      $display("lfu_cache_slot_manager_test: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
